@@ hw/rtl/utf8v_pkg.sv @@
// shared types and constants for the utf-8 file name validator
// no dependencies; imported by utf8v_decode, utf8v_verdict and the top level
`timescale 1ns / 1ps

package utf8v_pkg;

  // result codes
  typedef enum logic [3:0] {
    STATUS_OK        = 4'd0,
    STATUS_EMPTY     = 4'd1,
    STATUS_TOO_LONG  = 4'd2,
    STATUS_DOT       = 4'd3,
    STATUS_EDGE      = 4'd4,
    STATUS_FORBIDDEN = 4'd5,
    STATUS_BAD_UTF8  = 4'd6,
    STATUS_CONTROL   = 4'd7,
    STATUS_RESERVED  = 4'd8
  } status_t;

  // first decode error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_UTF8 = 2'd1;
  localparam logic [1:0] ERR_PROBLEM  = 2'd2;

  // minimum code point classes of a multi-byte sequence
  localparam logic [1:0] MIN_CLASS_2B = 2'd1;
  localparam logic [1:0] MIN_CLASS_3B = 2'd2;
  localparam logic [1:0] MIN_CLASS_4B = 2'd3;

  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [12:0] COUNT_SAT = 13'd4096;
  localparam logic [2:0]  STEM_MAX  = 3'd5;

  // utf-8 decoder state
  typedef struct packed {
    logic [1:0]  remaining;
    logic [1:0]  min_class;
    logic [20:0] accum;
    logic [1:0]  err;
  } dec_state_t;

  // per-name bookkeeping outside the decoder
  typedef struct packed {
    logic [12:0] count;
    logic [7:0]  prev;
    logic        leading_space;
    logic        double_dot;
    logic        forbidden;
    logic [31:0] stem_chars;
    logic [2:0]  stem_len;
    logic        stem_closed;
  } name_state_t;

endpackage

@@ hw/rtl/utf8_filename_validator.sv @@
// top level of the utf-8 file name validator: input register, per-byte checks, status register
// depends on utf8v_pkg, utf8v_decode and utf8v_verdict
`timescale 1ns / 1ps

// usage
//   input channel (in_valid / in_ready): one byte of a name per transfer, with
//   name_byte, last_byte marking the final byte and empty_name standing for a
//   zero-length name (byte and last flag then ignored, any name in progress dropped)
//   output channel (out_valid / out_ready): one 4-bit status per name, given
//   for the transfer that carries last_byte or empty_name; other bytes give none
//   config: cfg_we writes cfg_data into max_name_bytes in the same edge; the user must
//   write only while no name is in flight, as the block itself does not enforce it
// throughput and path
//   one byte per cycle while the status register can take a final byte; a
//   final byte passes through the input register, then the status register,
//   before its status is on the output
//   the byte checks and the utf-8 step are all combinational compare logic
// reset
//   rst (synchronous) drops any name in progress, empties both registers and
//   sets max_name_bytes back to 255
// stall
//   while a status waits for out_ready, plain bytes keep flowing; a final byte
//   holds in the input register until the status register frees up, and the
//   input then backs up through in_ready
module utf8_filename_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  name_byte,
  input  logic        last_byte,
  input  logic        empty_name,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  input  logic        cfg_we,
  input  logic [11:0] cfg_data
);
  import utf8v_pkg::*;

  // input register
  logic        in_q_valid;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        in_empty_q;

  // per-name state
  name_state_t name_st;
  name_state_t name_st_next;
  dec_state_t  dec_st;
  dec_state_t  dec_st_next;

  logic [11:0] max_name_bytes;

  // status register
  status_t     status_q;
  status_t     verdict;

  logic        ends_name;
  logic        advance;
  logic        byte_forbidden;
  logic [7:0]  byte_upper;

  assign ends_name = in_last_q | in_empty_q;
  // a plain byte never needs the status register; a final byte needs it free
  assign advance   = in_q_valid & (~ends_name | ~out_valid | out_ready);
  assign in_ready  = ~in_q_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_q  <= name_byte;
      in_last_q  <= last_byte;
      in_empty_q <= empty_name;
    end
  end

  // separator and punctuation bytes not allowed in a name
  assign byte_forbidden = in_byte_q == 8'h2f || in_byte_q == 8'h5c || in_byte_q == 8'h3a ||
                          in_byte_q == 8'h2a || in_byte_q == 8'h3f || in_byte_q == 8'h22 ||
                          in_byte_q == 8'h3c || in_byte_q == 8'h3e || in_byte_q == 8'h7c;

  // ascii fold to upper case for the device name stem
  assign byte_upper = (in_byte_q >= 8'h61 && in_byte_q <= 8'h7a) ?
                      in_byte_q - 8'd32 : in_byte_q;

  always_comb begin
    name_st_next = name_st;
    // count saturates at 4096, above any register value
    if (name_st.count != COUNT_SAT) name_st_next.count = name_st.count + 13'd1;
    if (name_st_next.count == 13'd1) name_st_next.leading_space = in_byte_q == CHAR_SPACE;
    if (name_st_next.count > 13'd1 && name_st.prev == CHAR_DOT && in_byte_q == CHAR_DOT)
      name_st_next.double_dot = 1'b1;
    if (byte_forbidden) name_st_next.forbidden = 1'b1;
    // stem ends at the first dot; keep the last four of its first five upper-cased bytes
    if (!name_st.stem_closed) begin
      if (in_byte_q == CHAR_DOT) begin
        name_st_next.stem_closed = 1'b1;
      end else if (name_st.stem_len < STEM_MAX) begin
        name_st_next.stem_chars = {name_st.stem_chars[23:0], byte_upper};
        name_st_next.stem_len   = name_st.stem_len + 3'd1;
      end
    end
    name_st_next.prev = in_byte_q;
  end

  utf8v_decode u_decode (
    .data_byte (in_byte_q),
    .cur       (dec_st),
    .nxt       (dec_st_next)
  );

  utf8v_verdict u_verdict (
    .last_char (in_byte_q),
    .max_bytes (max_name_bytes),
    .name_st   (name_st_next),
    .dec_st    (dec_st_next),
    .verdict   (verdict)
  );

  // name state clears after every status
  always_ff @(posedge clk) begin
    if (rst) begin
      name_st <= '0;
      dec_st  <= '0;
    end else if (advance) begin
      if (ends_name) begin
        name_st <= '0;
        dec_st  <= '0;
      end else begin
        name_st <= name_st_next;
        dec_st  <= dec_st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_name_bytes <= 12'd255;
    end else if (cfg_we) begin
      max_name_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && ends_name) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ends_name) begin
      status_q <= in_empty_q ? STATUS_EMPTY : verdict;
    end
  end

  assign status = status_q;

`ifndef SYNTHESIS
  // an empty-name marker always answers empty on the next cycle
  a_empty_answer: assert property (@(posedge clk) disable iff (rst)
    advance && in_empty_q |=> out_valid && status_q == STATUS_EMPTY)
    else $error("empty name did not give the empty status");

  // bookkeeping is cleared once a name ends
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    advance && ends_name |=> name_st.count == 13'd0 && dec_st == '0)
    else $error("name state not cleared after status");

  // byte count never passes its saturation value
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    name_st.count <= COUNT_SAT)
    else $error("byte count beyond saturation");

  // once a decode error is kept, the decoder freezes for the rest of the name
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    advance && !ends_name && dec_st.err != ERR_NONE |=> $stable(dec_st))
    else $error("decoder moved after its first error");

  // a plain byte never blocks behind a waiting status
  a_plain_flows: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !ends_name |-> advance)
    else $error("plain byte stalled in the input register");
`endif

endmodule

@@ hw/rtl/utf8v_decode.sv @@
// one-byte step of the utf-8 decoder with code point screening
// depends on utf8v_pkg
`timescale 1ns / 1ps

module utf8v_decode (
  input  logic [7:0]            data_byte,
  input  utf8v_pkg::dec_state_t cur,
  output utf8v_pkg::dec_state_t nxt
);
  import utf8v_pkg::*;

  function automatic logic is_problem(input logic [20:0] cp);
    return cp < 21'h20 || cp == 21'h7f ||
           (cp >= 21'h80 && cp <= 21'h9f) ||
           (cp >= 21'h300 && cp <= 21'h36f) ||
           (cp >= 21'h1ab0 && cp <= 21'h1aff) ||
           (cp >= 21'h1dc0 && cp <= 21'h1dff) ||
           (cp >= 21'h200b && cp <= 21'h200f) ||
           cp == 21'h2028 || cp == 21'h2029 ||
           (cp >= 21'h202a && cp <= 21'h202e) ||
           (cp >= 21'h2060 && cp <= 21'h206f) ||
           (cp >= 21'h20d0 && cp <= 21'h20ff) ||
           cp == 21'h2215 || cp == 21'h29f8 ||
           cp == 21'hfeff || cp == 21'hff0f || cp == 21'hff3c;
  endfunction

  logic [20:0] code;
  logic        below_min;

  assign code = {cur.accum[14:0], data_byte[5:0]};

  always_comb begin
    unique case (cur.min_class)
      MIN_CLASS_2B: below_min = code < 21'h80;
      MIN_CLASS_3B: below_min = code < 21'h800;
      default:      below_min = code < 21'h10000;
    endcase
  end

  always_comb begin
    nxt = cur;
    if (cur.err == ERR_NONE) begin
      if (cur.remaining == 2'd0) begin
        if (data_byte <= 8'h7f) begin
          if (is_problem({13'd0, data_byte})) nxt.err = ERR_PROBLEM;
        end else if (data_byte >= 8'hc2 && data_byte <= 8'hdf) begin
          nxt.remaining = 2'd1;
          nxt.min_class = MIN_CLASS_2B;
          nxt.accum     = {16'd0, data_byte[4:0]};
        end else if (data_byte >= 8'he0 && data_byte <= 8'hef) begin
          nxt.remaining = 2'd2;
          nxt.min_class = MIN_CLASS_3B;
          nxt.accum     = {17'd0, data_byte[3:0]};
        end else if (data_byte >= 8'hf0 && data_byte <= 8'hf4) begin
          nxt.remaining = 2'd3;
          nxt.min_class = MIN_CLASS_4B;
          nxt.accum     = {18'd0, data_byte[2:0]};
        end else begin
          nxt.err = ERR_BAD_UTF8;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        nxt.err = ERR_BAD_UTF8;
      end else begin
        nxt.accum     = code;
        nxt.remaining = cur.remaining - 2'd1;
        // sequence complete: overlong, range, surrogate and screening checks
        if (cur.remaining == 2'd1) begin
          if (below_min || code > 21'h10ffff || (code >= 21'hd800 && code <= 21'hdfff))
            nxt.err = ERR_BAD_UTF8;
          else if (is_problem(code))
            nxt.err = ERR_PROBLEM;
        end
      end
    end
  end

endmodule

@@ hw/rtl/utf8v_verdict.sv @@
// final status of a name from its updated bookkeeping and decoder state
// depends on utf8v_pkg
`timescale 1ns / 1ps

module utf8v_verdict (
  input  logic [7:0]             last_char,
  input  logic [11:0]            max_bytes,
  input  utf8v_pkg::name_state_t name_st,
  input  utf8v_pkg::dec_state_t  dec_st,
  output utf8v_pkg::status_t     verdict
);
  import utf8v_pkg::*;

  localparam logic [23:0] DEV_CON = "CON";
  localparam logic [23:0] DEV_PRN = "PRN";
  localparam logic [23:0] DEV_AUX = "AUX";
  localparam logic [23:0] DEV_NUL = "NUL";
  localparam logic [23:0] DEV_COM = "COM";
  localparam logic [23:0] DEV_LPT = "LPT";
  localparam logic [7:0]  DIGIT_1 = "1";
  localparam logic [7:0]  DIGIT_9 = "9";

  logic [1:0]  err_final;
  logic        reserved;
  logic [23:0] stem3;
  logic [23:0] head;
  logic [7:0]  digit;

  assign stem3 = name_st.stem_chars[23:0];
  assign head  = name_st.stem_chars[31:8];
  assign digit = name_st.stem_chars[7:0];

  // an open sequence at the end counts as truncated
  assign err_final = (dec_st.remaining != 2'd0 && dec_st.err == ERR_NONE) ?
                     ERR_BAD_UTF8 : dec_st.err;

  assign reserved =
    (name_st.stem_len == 3'd3 &&
     (stem3 == DEV_CON || stem3 == DEV_PRN || stem3 == DEV_AUX || stem3 == DEV_NUL)) ||
    (name_st.stem_len == 3'd4 && (head == DEV_COM || head == DEV_LPT) &&
     digit >= DIGIT_1 && digit <= DIGIT_9);

  always_comb begin
    priority if (name_st.count > {1'b0, max_bytes})
      verdict = STATUS_TOO_LONG;
    else if ((name_st.count == 13'd1 && last_char == CHAR_DOT) || name_st.double_dot)
      verdict = STATUS_DOT;
    else if (name_st.leading_space || last_char == CHAR_SPACE || last_char == CHAR_DOT)
      verdict = STATUS_EDGE;
    else if (name_st.forbidden)
      verdict = STATUS_FORBIDDEN;
    else if (err_final == ERR_BAD_UTF8)
      verdict = STATUS_BAD_UTF8;
    else if (err_final == ERR_PROBLEM)
      verdict = STATUS_CONTROL;
    else if (reserved)
      verdict = STATUS_RESERVED;
    else
      verdict = STATUS_OK;
  end

endmodule
